// ===== hw/rtl/acp_pkg.sv =====
// shared types, character constants and command codes of the ascii command parser
// no dependencies
`default_nettype none

package acp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_V     = 8'd86;
  localparam logic [7:0] CH_N     = 8'd78;

  localparam logic [3:0] CMD_UNKNOWN = 4'd0;
  localparam logic [3:0] CMD_N       = 4'd1;
  localparam logic [3:0] CMD_X       = 4'd2;
  localparam logic [3:0] CMD_Y       = 4'd3;
  localparam logic [3:0] CMD_Z       = 4'd4;
  localparam logic [3:0] CMD_W       = 4'd5;
  localparam logic [3:0] CMD_I       = 4'd6;
  localparam logic [3:0] CMD_U       = 4'd7;
  localparam logic [3:0] CMD_P       = 4'd8;
  localparam logic [3:0] CMD_S       = 4'd9;
  localparam logic [3:0] CMD_VX      = 4'd10;
  localparam logic [3:0] CMD_VY      = 4'd11;
  localparam logic [3:0] CMD_VZ      = 4'd12;
  localparam logic [3:0] CMD_VW      = 4'd13;

  localparam logic [3:0] FRAC_COUNT_MAX = 4'd15;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    TK_COMMA,
    TK_LF,
    TK_CR,
    TK_POINT,
    TK_N,
    TK_V,
    TK_CHAR
  } tok_kind_t;

  // digit is (byte - 48) as a signed 9-bit value
  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  letter;
    logic [3:0]  axis;
    logic [8:0]  digit;
  } token_t;

  typedef enum logic [1:0] {
    POS_LETTER,
    POS_AFTER_LETTER,
    POS_AFTER_AXIS,
    POS_DIGITS
  } pos_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] integer_part;
    logic [31:0] fraction_digits_value;
    logic [3:0]  fraction_digit_count;
    logic        has_point;
    logic        line_end;
  } result_t;

  function automatic logic [3:0] letter_code(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      8'h58:   c = CMD_X;
      8'h59:   c = CMD_Y;
      8'h5a:   c = CMD_Z;
      8'h57:   c = CMD_W;
      8'h49:   c = CMD_I;
      8'h55:   c = CMD_U;
      8'h50:   c = CMD_P;
      8'h53:   c = CMD_S;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] axis_code(input logic [7:0] b);
    logic [3:0] c;
    case (b)
      8'h58:   c = CMD_VX;
      8'h59:   c = CMD_VY;
      8'h5a:   c = CMD_VZ;
      8'h57:   c = CMD_VW;
      default: c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acp_front.sv =====
// front end: accepts received bytes and classifies them into tokens
// depends on acp_pkg
`default_nettype none

module acp_front import acp_pkg::*; (
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // rx_byte
  input  wire logic       queue_full,
  output logic            push,
  output token_t          push_token
);

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    push_token.letter = letter_code(s_axis_tdata);
    push_token.axis   = axis_code(s_axis_tdata);
    push_token.digit  = {1'b0, s_axis_tdata} - {1'b0, CH_ZERO};
    case (s_axis_tdata)
      CH_COMMA: push_token.kind = TK_COMMA;
      CH_LF:    push_token.kind = TK_LF;
      CH_CR:    push_token.kind = TK_CR;
      CH_POINT: push_token.kind = TK_POINT;
      CH_N:     push_token.kind = TK_N;
      CH_V:     push_token.kind = TK_V;
      default:  push_token.kind = TK_CHAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acp_fifo.sv =====
// short token queue between front and back end
// depends on acp_pkg
`default_nettype none

module acp_fifo import acp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire token_t push_token,
  output logic        full,
  input  wire logic   pop,
  output logic        valid,
  output token_t      head
);

  token_t             entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acp_back.sv =====
// back end: parameter state, decimal accumulation and the output register
// depends on acp_pkg
`default_nettype none

module acp_back import acp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         tok_valid,
  input  wire token_t       tok,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,
  output logic [3:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  pos_t        pos, pos_next;
  logic [3:0]  cmd, cmd_next;
  logic [31:0] int_acc, int_acc_next;
  logic [31:0] frac_acc, frac_acc_next;
  logic [3:0]  frac_cnt, frac_cnt_next;
  logic        point_seen, point_seen_next;
  logic        v_pending, v_pending_next;
  logic        emitted, emitted_next;
  logic        active, active_next;

  logic        emit;
  result_t     res;
  result_t     out_reg;
  logic        out_valid;
  logic [31:0] digit_ext;
  logic [31:0] acc_sel;
  logic [31:0] acc_mac;

  assign pop       = tok_valid && (!out_valid || m_axis_tready);
  assign digit_ext = {{23{tok.digit[8]}}, tok.digit};
  assign acc_sel   = point_seen ? frac_acc : int_acc;
  // times ten as two shifts
  assign acc_mac   = {acc_sel[28:0], 3'b000} + {acc_sel[30:0], 1'b0} + digit_ext;

  always_comb begin
    pos_next        = pos;
    cmd_next        = cmd;
    int_acc_next    = int_acc;
    frac_acc_next   = frac_acc;
    frac_cnt_next   = frac_cnt;
    point_seen_next = point_seen;
    v_pending_next  = v_pending;
    emitted_next    = emitted;
    active_next     = active;
    emit            = 1'b0;
    res.command               = cmd;
    res.integer_part          = int_acc;
    res.fraction_digits_value = frac_acc;
    res.fraction_digit_count  = frac_cnt;
    res.has_point             = point_seen;
    res.line_end              = (tok.kind == TK_LF);

    if (tok.kind == TK_COMMA || tok.kind == TK_LF) begin
      emit            = active && !emitted;
      pos_next        = POS_LETTER;
      cmd_next        = CMD_UNKNOWN;
      int_acc_next    = '0;
      frac_acc_next   = '0;
      frac_cnt_next   = '0;
      point_seen_next = 1'b0;
      v_pending_next  = 1'b0;
      emitted_next    = 1'b0;
      active_next     = 1'b0;
    end else if (tok.kind != TK_CR && !emitted) begin
      active_next = 1'b1;
      case (pos)
        POS_LETTER: begin
          pos_next = POS_AFTER_LETTER;
          if (tok.kind == TK_N) begin
            // N answers at once with a zero value
            cmd_next     = CMD_N;
            emitted_next = 1'b1;
            emit         = 1'b1;
            res.command  = CMD_N;
            res.line_end = 1'b0;
          end else if (tok.kind == TK_V) begin
            v_pending_next = 1'b1;
            cmd_next       = CMD_UNKNOWN;
          end else begin
            cmd_next = tok.letter;
          end
        end
        POS_AFTER_LETTER: begin
          if (v_pending) begin
            cmd_next       = tok.axis;
            v_pending_next = 1'b0;
            pos_next       = POS_AFTER_AXIS;
          end else begin
            pos_next = POS_DIGITS;
          end
        end
        POS_AFTER_AXIS: begin
          pos_next = POS_DIGITS;
        end
        default: begin
          if (tok.kind == TK_POINT) begin
            point_seen_next = 1'b1;
          end else if (point_seen) begin
            frac_acc_next = acc_mac;
            if (frac_cnt != FRAC_COUNT_MAX) begin
              frac_cnt_next = frac_cnt + 1'b1;
            end
          end else begin
            int_acc_next = acc_mac;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_LETTER;
      cmd        <= CMD_UNKNOWN;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      point_seen <= 1'b0;
      v_pending  <= 1'b0;
      emitted    <= 1'b0;
      active     <= 1'b0;
    end else if (pop) begin
      pos        <= pos_next;
      cmd        <= cmd_next;
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      frac_cnt   <= frac_cnt_next;
      point_seen <= point_seen_next;
      v_pending  <= v_pending_next;
      emitted    <= emitted_next;
      active     <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_reg.has_point, out_reg.fraction_digit_count,
                          out_reg.fraction_digits_value, out_reg.integer_part};
  assign m_axis_tuser  = out_reg.command;
  assign m_axis_tlast  = out_reg.line_end;

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_axis_command_parser.sv =====
// top level of the ascii command parser: front end, token queue, back end
// depends on acp_pkg, acp_front, acp_fifo, acp_back
//
// usage:
//   s_axis carries one received character per request in tdata. lines end in
//   cr lf, parameters are split by commas. m_axis carries one request per
//   finished parameter: command code in tuser, integer and fraction values,
//   fraction digit count and point flag in tdata, tlast set when the
//   parameter closed its line. an n command answers on the letter itself.
//   throughput is one character per cycle while the receiver keeps up: the front end classifies a byte
//   in the accept cycle, the back end retires one token per cycle with its
//   times-ten accumulate unless its output register is held. the closing
//   character passes through the token queue and the output register to m_axis_tvalid.
//   a four-entry token queue sits between the two halves; when the receiver
//   stalls the back end holds its output register and stops retiring, the
//   queue fills and s_axis_tready drops once it is full.
//   rst (synchronous) empties the queue, drops the output request and
//   returns the parser to the start of a parameter.
`default_nettype none

module ascii_axis_command_parser import acp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // integer_part, fraction_digits_value, fraction_digit_count, has_point, zero pad
  output logic [71:0]      m_axis_tdata,
  output logic [3:0]       m_axis_tuser,   // command
  output logic             m_axis_tlast    // line_end
);

  logic   queue_full;
  logic   push;
  token_t push_token;
  logic   pop;
  logic   head_valid;
  token_t head;

  acp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full    (queue_full),
    .push          (push),
    .push_token    (push_token)
  );

  acp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .valid      (head_valid),
    .head       (head)
  );

  acp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tok_valid     (head_valid),
    .tok           (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/acp_stream_checker.sv =====
// stream checker for the ascii command parser: watches both channels, predicts every
// parameter result from the accepted characters and compares field by field
// depends on acp_pkg
`timescale 1ns / 1ps

module acp_stream_checker import acp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          err_count,
  output int          pending,
  output int          checked
);

  localparam logic [31:0] RADIX = 32'd10;

  // parser state as predicted
  pos_t        pos;
  logic [3:0]  cmd;
  logic [31:0] int_acc;
  logic [31:0] frac_acc;
  logic [3:0]  frac_cnt;
  logic        pt_seen;
  logic        v_pend;
  logic        n_done;
  logic        active;

  result_t     expected_params[$];
  result_t     want;

  function automatic void start_param();
    pos      = POS_LETTER;
    cmd      = CMD_UNKNOWN;
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = '0;
    pt_seen  = 1'b0;
    v_pend   = 1'b0;
    n_done   = 1'b0;
    active   = 1'b0;
  endfunction

  function automatic logic [3:0] letter_to_cmd(input logic [7:0] b);
    case (b)
      "X":     return CMD_X;
      "Y":     return CMD_Y;
      "Z":     return CMD_Z;
      "W":     return CMD_W;
      "I":     return CMD_I;
      "U":     return CMD_U;
      "P":     return CMD_P;
      "S":     return CMD_S;
      default: return CMD_UNKNOWN;
    endcase
  endfunction

  function automatic logic [3:0] axis_to_cmd(input logic [7:0] b);
    case (b)
      "X":     return CMD_VX;
      "Y":     return CMD_VY;
      "Z":     return CMD_VZ;
      "W":     return CMD_VW;
      default: return CMD_UNKNOWN;
    endcase
  endfunction

  // advances the parser by one character, returns 1 when a parameter result is due
  function automatic bit parse_char(input logic [7:0] b, output result_t r);
    logic [31:0] d;
    bit          hit;
    r = '0;
    if (b == CH_LF || b == CH_COMMA) begin
      hit = active && !n_done;
      r.command               = cmd;
      r.integer_part          = int_acc;
      r.fraction_digits_value = frac_acc;
      r.fraction_digit_count  = frac_cnt;
      r.has_point             = pt_seen;
      r.line_end              = (b == CH_LF);
      start_param();
      return hit;
    end
    if (b == CH_CR || n_done) return 1'b0;
    active = 1'b1;
    case (pos)
      POS_LETTER: begin
        pos = POS_AFTER_LETTER;
        if (b == CH_N) begin
          // n answers on the letter, rest of the parameter is dropped
          cmd       = CMD_N;
          n_done    = 1'b1;
          r.command = CMD_N;
          return 1'b1;
        end
        if (b == CH_V) begin
          v_pend = 1'b1;
          cmd    = CMD_UNKNOWN;
        end else begin
          cmd = letter_to_cmd(b);
        end
      end
      POS_AFTER_LETTER: begin
        if (v_pend) begin
          cmd    = axis_to_cmd(b);
          v_pend = 1'b0;
          pos    = POS_AFTER_AXIS;
        end else begin
          pos = POS_DIGITS;
        end
      end
      POS_AFTER_AXIS: pos = POS_DIGITS;
      default: begin
        if (b == CH_POINT) begin
          pt_seen = 1'b1;
        end else begin
          // non-digit bytes wrap like unsigned arithmetic
          d = {24'd0, b} - {24'd0, CH_ZERO};
          if (pt_seen) begin
            frac_acc = frac_acc * RADIX + d;
            if (frac_cnt != FRAC_COUNT_MAX) frac_cnt = frac_cnt + 4'd1;
          end else begin
            int_acc = int_acc * RADIX + d;
          end
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_val, input logic [31:0] got);
    err_count++;
    if (err_count <= 30)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field, exp_val, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_param();
      expected_params.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready && parse_char(s_axis_tdata, want))
        expected_params.push_back(want);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_params.size() == 0) begin
          report("unexpected result, command", '0, {28'd0, m_axis_tuser});
        end else begin
          want = expected_params.pop_front();
          checked++;
          if (m_axis_tuser != want.command)
            report("command", {28'd0, want.command}, {28'd0, m_axis_tuser});
          if (m_axis_tdata[31:0] != want.integer_part)
            report("integer_part", want.integer_part, m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] != want.fraction_digits_value)
            report("fraction_digits_value", want.fraction_digits_value, m_axis_tdata[63:32]);
          if (m_axis_tdata[67:64] != want.fraction_digit_count)
            report("fraction_digit_count", {28'd0, want.fraction_digit_count},
                   {28'd0, m_axis_tdata[67:64]});
          if (m_axis_tdata[68] != want.has_point)
            report("has_point", {31'd0, want.has_point}, {31'd0, m_axis_tdata[68]});
          if (m_axis_tdata[71:69] != 3'd0)
            report("tdata padding", '0, {29'd0, m_axis_tdata[71:69]});
          if (m_axis_tlast != want.line_end)
            report("line_end", {31'd0, want.line_end}, {31'd0, m_axis_tlast});
        end
      end
    end
    pending = expected_params.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the ascii command parser testbench: clock, reset, character stimulus with
// random gaps, random receiver stalls and the verdict; depends on acp_pkg,
// acp_stream_checker and the parser rtl
`timescale 1ns / 1ps

module tb_top;
  import acp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;   // integer_part, fraction_digits_value, count, has_point, pad
  logic [3:0]  m_axis_tuser;   // command
  logic        m_axis_tlast;   // line_end

  int err_count;
  int pending;
  int checked;
  int sent;
  bit calm;                     // stretch with no idling on either side

  ascii_axis_command_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  acp_stream_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_count     (err_count),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    calm = (sent % 160) < 40;
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // any byte that does not close a parameter
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA || b == CH_LF);
    return b;
  endfunction

  task automatic send_digits(input int n);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send_byte(junk_byte());
      else send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // one parameter, mostly well formed with random content
  task automatic send_param();
    string letters;
    string axes;
    int    kind;
    letters = "XYZWIUPS";
    axes    = "XYZW";
    kind    = $urandom_range(0, 9);
    if (kind == 0) begin
      send_byte(CH_N);
      repeat ($urandom_range(0, 4)) send_byte(junk_byte());
      return;
    end
    if (kind <= 2) begin
      send_byte(CH_V);
      if ($urandom_range(0, 4) == 0) send_byte(junk_byte());
      else send_byte(axes[$urandom_range(0, 3)]);
    end else if ($urandom_range(0, 5) == 0) begin
      send_byte(junk_byte());
    end else begin
      send_byte(letters[$urandom_range(0, 7)]);
    end
    if ($urandom_range(0, 9) == 0) return;
    // the skipped separator, now and then a point or junk
    case ($urandom_range(0, 7))
      0:       send_byte(CH_POINT);
      1:       send_byte(junk_byte());
      default: send_str(" ");
    endcase
    if ($urandom_range(0, 7) == 0) send_digits($urandom_range(5, 14));
    else send_digits($urandom_range(0, 4));
    if ($urandom_range(0, 1) == 0) begin
      send_byte(CH_POINT);
      if ($urandom_range(0, 7) == 0) send_digits($urandom_range(14, 20));
      else send_digits($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) begin
        send_byte(CH_POINT);
        send_digits($urandom_range(0, 3));
      end
    end
  endtask

  task automatic send_line();
    int nparam;
    if ($urandom_range(0, 9) == 0) begin
      // noise line
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_LF);
      return;
    end
    nparam = $urandom_range(0, 4);
    for (int i = 0; i < nparam; i++) begin
      if (i > 0) send_byte(CH_COMMA);
      if ($urandom_range(0, 11) != 0) send_param();
    end
    case ($urandom_range(0, 9))
      0:       send_str(",\r\n");
      1:       send_byte(CH_LF);
      default: send_str("\r\n");
    endcase
  endtask

  // receiver with random stalls per result
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: n with trailing content, v axis with a second point and cr lf
    send_str("N5,VX 1.2.\r\n");
    // empty parameter, then an empty line
    send_str(",\n");
    // unknown letter, short parameter closing a line
    send_str("Q\n");
    // byte extremes in the digit section
    send_str("I ");
    send_byte(8'hFF);
    send_byte(CH_POINT);
    send_byte(8'h00);
    send_byte(CH_LF);
    // point at the end of the digits
    send_str("S 7.,");
    while (sent < 960) send_line();
    send_byte(CH_LF);
    s_axis_tvalid <= 1'b0;
    // let the checker book the last character before looking at the backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("fed %0d characters, compared %0d parameter results", sent, checked);
    if (err_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
